// ===== rtl/core/pfm_pkg.sv =====
// ----------------------------------------------------------------------------
// pfm_pkg
// Shared widths, constants, payload types and rounding helpers of the plane
// frame matrix core.
// ----------------------------------------------------------------------------
package pfm_pkg;

  localparam int VEC_W      = 16;              // Q4.12 vector component
  localparam int UNIT_W     = 14;              // unit component, within +-4096
  localparam int SCALE_W    = 15;              // unsigned Q3.12 scale
  localparam int FRAC_W     = 12;
  localparam int SS_W       = 32;              // sum of three squares
  localparam int LEN_W      = 28;              // length in Q.24
  localparam int SQ_XW      = 2 * LEN_W;       // radicand of the square root
  localparam int QUO_W      = 13;              // magnitude of a unit component
  localparam int DIV_W      = 42;              // divider remainder
  localparam int DIV_SHIFT  = 2 * FRAC_W + 1;  // doubled numerator in Q.36

  localparam int Q_ONE       = 4096;
  localparam int TINY_SS_MAX = 16;             // raw length below 0.001
  localparam int NEAR_Y_MUL  = 100;
  localparam int NEAR_Y_LIM  = 99 * Q_ONE;

  localparam int NORM_STAGES = 2 + LEN_W + QUO_W;
  localparam int EMIT_STAGES = 4;
  localparam int LATENCY     = 2 * NORM_STAGES + 1 + EMIT_STAGES;

  typedef struct packed {
    logic                        action;
    logic [2:0][VEC_W-1:0]       origin;
    logic [SCALE_W-1:0]          scale;
  } side_t;

  typedef struct packed {
    side_t                       side;
    logic [2:0][UNIT_W-1:0]      n;
  } frame_t;

  // Q.24 to Q.12, round half toward +infinity.
  function automatic logic signed [27:0] round12(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = v + 40'sd2048;
    return t[39:12];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
    logic signed [15:0] r;
    if (v > 28'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -28'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pfm_isqrt.sv =====
// ----------------------------------------------------------------------------
// pfm_isqrt
// Pipelined integer square root, one result bit per register stage, with a
// sideband that travels alongside each item.
// ----------------------------------------------------------------------------
module pfm_isqrt #(
  parameter int TW = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [pfm_pkg::SQ_XW-1:0]    x_i,
  input  logic [TW-1:0]                tag_i,
  output logic                         valid_o,
  output logic [pfm_pkg::LEN_W-1:0]    root_o,
  output logic [TW-1:0]                tag_o
);

  localparam int XW = pfm_pkg::SQ_XW;
  localparam int RW = pfm_pkg::LEN_W;

  logic          vld_q [RW];
  logic [XW-1:0] rem_q [RW];
  logic [XW-1:0] res_q [RW];
  logic [TW-1:0] tag_q [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam logic [XW:0] StepBit = (XW+1)'(1) << (XW - 2 - 2 * j);

    logic          v_in;
    logic [XW-1:0] rem_in;
    logic [XW-1:0] res_in;
    logic [TW-1:0] t_in;
    logic [XW:0]   trial;
    logic          take;

    if (j == 0) begin : g_head
      assign v_in   = valid_i;
      assign rem_in = x_i;
      assign res_in = '0;
      assign t_in   = tag_i;
    end else begin : g_body
      assign v_in   = vld_q[j-1];
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
      assign t_in   = tag_q[j-1];
    end

    assign trial = {1'b0, res_in} + StepBit;
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[j] <= t_in;
      if (take) begin
        rem_q[j] <= rem_in - trial[XW-1:0];
        res_q[j] <= (res_in >> 1) + StepBit[XW-1:0];
      end else begin
        rem_q[j] <= rem_in;
        res_q[j] <= res_in >> 1;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = res_q[RW-1][RW-1:0];
  assign tag_o   = tag_q[RW-1];

endmodule

// ===== rtl/core/pfm_norm.sv =====
// ----------------------------------------------------------------------------
// pfm_norm
// Pipelined vector normalizer: squares, sum, square root, then a restoring
// divider per lane that yields each Q2.12 unit component rounded to nearest.
// ----------------------------------------------------------------------------
module pfm_norm #(
  parameter int TW = 8
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  logic [2:0][pfm_pkg::VEC_W-1:0]            v_i,
  input  logic [TW-1:0]                             tag_i,
  output logic                                      valid_o,
  output logic [2:0][pfm_pkg::UNIT_W-1:0]           u_o,
  output logic                                      tiny_o,
  output logic [TW-1:0]                             tag_o
);

  localparam int VW = pfm_pkg::VEC_W;
  localparam int QW = pfm_pkg::QUO_W;
  localparam int NW = pfm_pkg::DIV_W;
  localparam int LW = pfm_pkg::LEN_W;
  localparam int SW = pfm_pkg::SS_W;

  typedef struct packed {
    logic [TW-1:0]        tag;
    logic [2:0][VW-1:0]   mag;
    logic [2:0]           sgn;
    logic                 zero;
    logic                 tiny;
  } meta_t;

  localparam int MW = $bits(meta_t);

  // Squares.
  logic                va_q;
  logic [2:0][SW-1:0]  sq_q;
  meta_t               meta_a_q;

  // Sum and short-length flags.
  logic                vb_q;
  logic [SW-1:0]       ss_q;
  meta_t               meta_b_q;
  logic [SW-1:0]       ss_d;
  meta_t               meta_b_d;

  always_comb begin
    ss_d          = sq_q[0] + sq_q[1] + sq_q[2];
    meta_b_d      = meta_a_q;
    meta_b_d.zero = ss_d == '0;
    meta_b_d.tiny = ss_d <= SW'(pfm_pkg::TINY_SS_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i]         <= $signed(v_i[i]) * $signed(v_i[i]);
      meta_a_q.mag[i] <= v_i[i][VW-1] ? VW'(-v_i[i]) : v_i[i];
      meta_a_q.sgn[i] <= v_i[i][VW-1];
    end
    meta_a_q.tag  <= tag_i;
    meta_a_q.zero <= 1'b0;
    meta_a_q.tiny <= 1'b0;

    ss_q     <= ss_d;
    meta_b_q <= meta_b_d;
  end

  // Length in Q.24.
  logic          vs_w;
  logic [LW-1:0] root_w;
  logic [MW-1:0] meta_s_w;

  pfm_isqrt #(
    .TW (MW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vb_q),
    .x_i     ({ss_q, (pfm_pkg::SQ_XW - SW)'(0)}),
    .tag_i   (meta_b_q),
    .valid_o (vs_w),
    .root_o  (root_w),
    .tag_o   (meta_s_w)
  );

  // Restoring divider, one quotient bit per stage on all three lanes.
  logic                dv_q   [QW];
  logic [2:0][NW-1:0]  drem_q [QW];
  logic [2:0][QW-1:0]  dquo_q [QW];
  logic [LW:0]         dden_q [QW];
  meta_t               dmeta_q[QW];

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;

    logic                v_in;
    logic [2:0][NW-1:0]  rem_in;
    logic [2:0][QW-1:0]  quo_in;
    logic [LW:0]         den_in;
    meta_t               meta_in;
    logic [NW-1:0]       trial;

    if (s == 0) begin : g_head
      meta_t m0;
      assign m0      = meta_s_w;
      assign v_in    = vs_w;
      assign den_in  = {root_w, 1'b0};
      assign quo_in  = '0;
      assign meta_in = m0;
      for (genvar l = 0; l < 3; l++) begin : g_lane0
        assign rem_in[l] = (NW'(m0.mag[l]) << pfm_pkg::DIV_SHIFT) + NW'(root_w);
      end
    end else begin : g_body
      assign v_in    = dv_q[s-1];
      assign den_in  = dden_q[s-1];
      assign quo_in  = dquo_q[s-1];
      assign meta_in = dmeta_q[s-1];
      assign rem_in  = drem_q[s-1];
    end

    assign trial = NW'(den_in) << K;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s] <= 1'b0;
      end else begin
        dv_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dden_q[s]  <= den_in;
      dmeta_q[s] <= meta_in;
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= trial) begin
          drem_q[s][l] <= rem_in[l] - trial;
          dquo_q[s][l] <= {quo_in[l][QW-2:0], 1'b1};
        end else begin
          drem_q[s][l] <= rem_in[l];
          dquo_q[s][l] <= {quo_in[l][QW-2:0], 1'b0};
        end
      end
    end
  end

  meta_t meta_o;
  assign meta_o = dmeta_q[QW-1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (meta_o.zero) begin
        u_o[l] = '0;
      end else if (meta_o.sgn[l]) begin
        u_o[l] = -{1'b0, dquo_q[QW-1][l]};
      end else begin
        u_o[l] = {1'b0, dquo_q[QW-1][l]};
      end
    end
  end

  assign valid_o = dv_q[QW-1];
  assign tiny_o  = meta_o.tiny;
  assign tag_o   = meta_o.tag;

endmodule

// ===== rtl/core/pfm_emit.sv =====
// ----------------------------------------------------------------------------
// pfm_emit
// Builds up = n x right and assembles either the scaled plane-to-world rows
// or the world-to-plane rows with their translations, over four stages.
// ----------------------------------------------------------------------------
module pfm_emit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic [2:0][pfm_pkg::UNIT_W-1:0]        r_i,
  input  pfm_pkg::frame_t                        frame_i,
  output logic                                   valid_o,
  output logic [2:0][3:0][pfm_pkg::VEC_W-1:0]    m_o
);

  localparam int VW = pfm_pkg::VEC_W;
  localparam int UW = pfm_pkg::UNIT_W;

  // Stage 1: cross-product partial products.
  logic                   v1_q;
  logic signed [2*UW-1:0] prod_q [6];
  logic [2:0][UW-1:0]     r1_q;
  pfm_pkg::frame_t        f1_q;

  // Stage 2: up vector.
  logic                   v2_q;
  logic signed [VW-1:0]   r2_q [3];
  logic signed [VW-1:0]   u2_q [3];
  logic signed [VW-1:0]   n2_q [3];
  pfm_pkg::side_t         s2_q;

  // Stage 3: scaled axes and dot-product terms.
  logic                   v3_q;
  logic signed [31:0]     rs_q [3];
  logic signed [31:0]     us_q [3];
  logic signed [31:0]     dot_q [3][3];
  logic signed [VW-1:0]   r3_q [3];
  logic signed [VW-1:0]   u3_q [3];
  logic signed [VW-1:0]   n3_q [3];
  pfm_pkg::side_t         s3_q;

  // Stage 4: output matrix.
  logic                        v4_q;
  logic [2:0][3:0][VW-1:0]     m_q;
  logic [2:0][3:0][VW-1:0]     m_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q[0] <= $signed(frame_i.n[1]) * $signed(r_i[2]);
    prod_q[1] <= $signed(frame_i.n[2]) * $signed(r_i[1]);
    prod_q[2] <= $signed(frame_i.n[2]) * $signed(r_i[0]);
    prod_q[3] <= $signed(frame_i.n[0]) * $signed(r_i[2]);
    prod_q[4] <= $signed(frame_i.n[0]) * $signed(r_i[1]);
    prod_q[5] <= $signed(frame_i.n[1]) * $signed(r_i[0]);
    r1_q      <= r_i;
    f1_q      <= frame_i;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      u2_q[i] <= VW'(pfm_pkg::round12(40'(prod_q[2*i]) - 40'(prod_q[2*i+1])));
      r2_q[i] <= VW'($signed(r1_q[i]));
      n2_q[i] <= VW'($signed(f1_q.n[i]));
    end
    s2_q <= f1_q.side;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      rs_q[i] <= 32'(r2_q[i]) * 32'($signed({1'b0, s2_q.scale}));
      us_q[i] <= 32'(u2_q[i]) * 32'($signed({1'b0, s2_q.scale}));
      dot_q[0][i] <= 32'(r2_q[i]) * 32'($signed(s2_q.origin[i]));
      dot_q[1][i] <= 32'(u2_q[i]) * 32'($signed(s2_q.origin[i]));
      dot_q[2][i] <= 32'(n2_q[i]) * 32'($signed(s2_q.origin[i]));
    end
    r3_q <= r2_q;
    u3_q <= u2_q;
    n3_q <= n2_q;
    s3_q <= s2_q;
  end

  always_comb begin
    logic signed [39:0] d;
    for (int j = 0; j < 3; j++) begin
      d = 40'(dot_q[j][0]) + 40'(dot_q[j][1]) + 40'(dot_q[j][2]);
      if (s3_q.action) begin
        m_d[j][0] = pfm_pkg::sat16(pfm_pkg::round12(40'(rs_q[j])));
        m_d[j][1] = pfm_pkg::sat16(pfm_pkg::round12(40'(us_q[j])));
        m_d[j][2] = n3_q[j];
        m_d[j][3] = s3_q.origin[j];
      end else begin
        m_d[j][3] = pfm_pkg::sat16(pfm_pkg::round12(-d));
        if (j == 0) begin
          m_d[j][0] = r3_q[0];
          m_d[j][1] = r3_q[1];
          m_d[j][2] = r3_q[2];
        end else if (j == 1) begin
          m_d[j][0] = u3_q[0];
          m_d[j][1] = u3_q[1];
          m_d[j][2] = u3_q[2];
        end else begin
          m_d[j][0] = n3_q[0];
          m_d[j][1] = n3_q[1];
          m_d[j][2] = n3_q[2];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
  end

  assign valid_o = v4_q;
  assign m_o     = m_q;

endmodule

// ===== rtl/core/plane_frame_matrix_core.sv =====
// ----------------------------------------------------------------------------
// plane_frame_matrix_core
// Orthonormal plane frame from a normal, emitted as a 3x4 affine matrix.
// ----------------------------------------------------------------------------
// The core takes one item in every clock cycle and never raises busy; each
// item returns exactly one matrix, marked by done_o for one cycle, after it
// passes through the two normalizers in series (each two stages of squares
// and their sum, a 28-stage square root and a 13-stage divider), one frame
// stage between them and four output stages. The receiver cannot stall, so
// results must be captured in the cycle that done_o is high.
//
// Operation: the normal is normalized to Q4.12; a normal whose raw length
// is below 0.001 is replaced by +Z. The reference axis is +Y, or +X when
// the unit normal's y component is at least 0.99 in magnitude. The right
// axis is the normalized cross product of the reference with the normal,
// and up is the normal crossed with right. With action high the matrix is
// plane-to-world, with right and up scaled by plane_scale and the origin as
// translation. With action low it is world-to-plane: rows right, up and n,
// each with the negated dot product of that row and the origin as
// translation. Every output is a saturated signed Q4.12 value.
// ----------------------------------------------------------------------------
module plane_frame_matrix_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 action_i,
  input  logic signed [15:0]   normal_x_i,
  input  logic signed [15:0]   normal_y_i,
  input  logic signed [15:0]   normal_z_i,
  input  logic signed [15:0]   origin_x_i,
  input  logic signed [15:0]   origin_y_i,
  input  logic signed [15:0]   origin_z_i,
  input  logic [14:0]          plane_scale_i,
  output logic                 done_o,
  output logic signed [15:0]   row0_col0_o,
  output logic signed [15:0]   row0_col1_o,
  output logic signed [15:0]   row0_col2_o,
  output logic signed [15:0]   row0_col3_o,
  output logic signed [15:0]   row1_col0_o,
  output logic signed [15:0]   row1_col1_o,
  output logic signed [15:0]   row1_col2_o,
  output logic signed [15:0]   row1_col3_o,
  output logic signed [15:0]   row2_col0_o,
  output logic signed [15:0]   row2_col1_o,
  output logic signed [15:0]   row2_col2_o,
  output logic signed [15:0]   row2_col3_o
);

  localparam int VW = pfm_pkg::VEC_W;
  localparam int UW = pfm_pkg::UNIT_W;

  // The pipeline advances every cycle, so the core is always ready.
  assign busy = 1'b0;

  pfm_pkg::side_t side_in;

  assign side_in.action = action_i;
  assign side_in.origin = {origin_z_i, origin_y_i, origin_x_i};
  assign side_in.scale  = plane_scale_i;

  // First normalizer: the plane normal, with the side data riding along.
  logic                  nv_w;
  logic [2:0][UW-1:0]    nu_w;
  logic                  ntiny_w;
  pfm_pkg::side_t        nside_w;

  pfm_norm #(
    .TW ($bits(pfm_pkg::side_t))
  ) u_norm_n (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .v_i     ({normal_z_i, normal_y_i, normal_x_i}),
    .tag_i   (side_in),
    .valid_o (nv_w),
    .u_o     (nu_w),
    .tiny_o  (ntiny_w),
    .tag_o   (nside_w)
  );

  // Frame stage: short-normal fallback, reference choice and ref x n.
  logic                  fv_q;
  pfm_pkg::frame_t       frame_q;
  logic [2:0][VW-1:0]    cr_q;
  logic [2:0][UW-1:0]    n_d;
  logic [UW-1:0]         ny_abs;
  logic                  near_y;
  logic [2:0][UW-1:0]    cr_d;

  always_comb begin
    if (ntiny_w) begin
      n_d[0] = '0;
      n_d[1] = '0;
      n_d[2] = UW'(pfm_pkg::Q_ONE);
    end else begin
      n_d = nu_w;
    end
    ny_abs = n_d[1][UW-1] ? -n_d[1] : n_d[1];
    near_y = (20'(ny_abs) * 20'(pfm_pkg::NEAR_Y_MUL)) >= 20'(pfm_pkg::NEAR_Y_LIM);
    if (near_y) begin
      // X x n
      cr_d[0] = '0;
      cr_d[1] = -n_d[2];
      cr_d[2] = n_d[1];
    end else begin
      // Y x n
      cr_d[0] = n_d[2];
      cr_d[1] = '0;
      cr_d[2] = -n_d[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= nv_w;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q.side <= nside_w;
    frame_q.n    <= n_d;
    for (int i = 0; i < 3; i++) begin
      cr_q[i] <= VW'($signed(cr_d[i]));
    end
  end

  // Second normalizer: the right axis.
  logic                  rv_w;
  logic [2:0][UW-1:0]    ru_w;
  logic                  rtiny_w;
  pfm_pkg::frame_t       rframe_w;

  pfm_norm #(
    .TW ($bits(pfm_pkg::frame_t))
  ) u_norm_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv_q),
    .v_i     (cr_q),
    .tag_i   (frame_q),
    .valid_o (rv_w),
    .u_o     (ru_w),
    .tiny_o  (rtiny_w),
    .tag_o   (rframe_w)
  );

  // The short-length flag only matters for the plane normal.
  logic                        ev_w;
  logic [2:0][3:0][VW-1:0]     m_w;

  pfm_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv_w & (rtiny_w | ~rtiny_w)),
    .r_i     (ru_w),
    .frame_i (rframe_w),
    .valid_o (ev_w),
    .m_o     (m_w)
  );

  assign done_o      = ev_w;
  assign row0_col0_o = m_w[0][0];
  assign row0_col1_o = m_w[0][1];
  assign row0_col2_o = m_w[0][2];
  assign row0_col3_o = m_w[0][3];
  assign row1_col0_o = m_w[1][0];
  assign row1_col1_o = m_w[1][1];
  assign row1_col2_o = m_w[1][2];
  assign row1_col3_o = m_w[1][3];
  assign row2_col0_o = m_w[2][0];
  assign row2_col1_o = m_w[2][1];
  assign row2_col2_o = m_w[2][2];
  assign row2_col3_o = m_w[2][3];

endmodule

// ===== rtl/core/pfm_checker.sv =====
// ----------------------------------------------------------------------------
// pfm_port_checker
// Port-level checks on item latency, pass-through fields and the zero-normal fallback.
// ----------------------------------------------------------------------------
module pfm_port_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 action_i,
  input  logic signed [15:0]   normal_x_i,
  input  logic signed [15:0]   normal_y_i,
  input  logic signed [15:0]   normal_z_i,
  input  logic signed [15:0]   origin_x_i,
  input  logic                 done_o,
  input  logic signed [15:0]   row0_col3_o,
  input  logic signed [15:0]   row2_col0_o,
  input  logic signed [15:0]   row2_col1_o,
  input  logic signed [15:0]   row2_col2_o
);

  localparam int Lat = pfm_pkg::LATENCY;

  // Every accepted item comes out after the fixed latency.
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o)
    else $error("accepted item produced no result");

  // No result appears without an item accepted the same latency earlier.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat))
    else $error("result without an accepted item");

  // Plane-to-world carries the origin as translation.
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(action_i, Lat)) |-> (row0_col3_o == $past(origin_x_i, Lat)))
    else $error("translation does not match origin");

  // A zero normal falls back to +Z in the third row.
  a_zero_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(normal_x_i, Lat) == 16'sd0 && $past(normal_y_i, Lat) == 16'sd0
     && $past(normal_z_i, Lat) == 16'sd0)
    |-> (row2_col0_o == 16'sd0 && row2_col1_o == 16'sd0 && row2_col2_o == 16'sd4096))
    else $error("zero normal did not fall back to +Z");

endmodule

bind plane_frame_matrix_core pfm_port_checker u_pfm_port_checker (.*);

// ===== test/pfm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfm_checker
// Watches the item and result channels of the plane frame matrix core,
// computes the expected matrix of every accepted item and compares results.
// ----------------------------------------------------------------------------
module pfm_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               action_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [15:0] origin_x_i,
  input  logic signed [15:0] origin_y_i,
  input  logic signed [15:0] origin_z_i,
  input  logic [14:0]        plane_scale_i,
  input  logic               done_i,
  input  logic [11:0][15:0]  matrix_i,
  output int                 err_cnt_o,
  output int                 pending_o,
  output int                 matrix_cnt_o
);

  typedef logic [11:0][15:0] matrix_t;
  matrix_t matrix_q[$];

  function automatic longint sqrt_floor(input longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint rnd_q12(input longint v);
    if (v >= 0) return (v + 2048) >>> 12;
    return -((-v + 2047) >>> 12);
  endfunction

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic void unit_vec(input longint v[3], output longint o[3]);
    longint unsigned ss, len, mag;
    ss = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    if (ss == 0) begin
      o = '{0, 0, 0};
      return;
    end
    len = sqrt_floor(ss << 24);
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0 ? -v[i] : v[i]) << 24;
      o[i] = (2 * mag + len) / (2 * len);
      if (v[i] < 0) o[i] = -o[i];
    end
  endfunction

  function automatic matrix_t frame_matrix(input logic act, input longint raw[3],
                                           input longint p[3], input longint s);
    longint n[3], cr[3], r[3], u[3], d;
    matrix_t m;
    longint ny;
    if ((raw[0] * raw[0] + raw[1] * raw[1] + raw[2] * raw[2]) * 1000000 < (64'd1 << 24))
      n = '{0, 0, 4096};
    else
      unit_vec(raw, n);
    ny = n[1] < 0 ? -n[1] : n[1];
    // Near-Y normals switch the reference axis to +X.
    if (ny * 100 >= 99 * 4096) cr = '{0, -n[2], n[1]};
    else cr = '{n[2], 0, -n[0]};
    unit_vec(cr, r);
    u[0] = rnd_q12(n[1] * r[2] - n[2] * r[1]);
    u[1] = rnd_q12(n[2] * r[0] - n[0] * r[2]);
    u[2] = rnd_q12(n[0] * r[1] - n[1] * r[0]);
    for (int i = 0; i < 3; i++) begin
      if (act) begin
        m[i*4+0] = clip16(rnd_q12(r[i] * s));
        m[i*4+1] = clip16(rnd_q12(u[i] * s));
        m[i*4+2] = clip16(n[i]);
        m[i*4+3] = clip16(p[i]);
      end else begin
        longint v[3];
        if (i == 0) v = r;
        else if (i == 1) v = u;
        else v = n;
        d = v[0] * p[0] + v[1] * p[1] + v[2] * p[2];
        m[i*4+0] = clip16(v[0]);
        m[i*4+1] = clip16(v[1]);
        m[i*4+2] = clip16(v[2]);
        m[i*4+3] = clip16(rnd_q12(-d));
      end
    end
    return m;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: MISMATCH %s", $realtime, what);
    err_cnt_o++;
  endtask

  initial begin
    err_cnt_o = 0;
    matrix_cnt_o = 0;
  end

  assign pending_o = matrix_q.size();

  always @(posedge clk_i) begin
    matrix_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (matrix_q.size() == 0) begin
          report_mismatch("matrix with no item waiting");
        end else begin
          want = matrix_q.pop_front();
          matrix_cnt_o++;
          for (int k = 0; k < 12; k++)
            if (matrix_i[k] !== want[k])
              report_mismatch($sformatf("row%0d_col%0d got %h want %h",
                                        k / 4, k % 4, matrix_i[k], want[k]));
        end
      end
      if (start_i && !busy_i)
        matrix_q.push_back(frame_matrix(action_i,
          '{longint'(normal_x_i), longint'(normal_y_i), longint'(normal_z_i)},
          '{longint'(origin_x_i), longint'(origin_y_i), longint'(origin_z_i)},
          longint'(plane_scale_i)));
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives plane items into the plane frame matrix core, directed corners
// first and random items after, across several idling phases.
// ----------------------------------------------------------------------------
module tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               action_i = 1'b0;
  logic signed [15:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic signed [15:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic [14:0]        plane_scale_i = '0;
  logic               done_o;
  logic [11:0][15:0]  matrix;
  int                 err_cnt, pending, matrix_cnt;
  int                 idle_pct;
  int                 item_cnt = 0;

  always #5 clk_i = ~clk_i;

  plane_frame_matrix_core DUT (
    .clk_i, .rst_ni, .start, .busy, .action_i,
    .normal_x_i, .normal_y_i, .normal_z_i,
    .origin_x_i, .origin_y_i, .origin_z_i, .plane_scale_i, .done_o,
    .row0_col0_o(matrix[0]), .row0_col1_o(matrix[1]),
    .row0_col2_o(matrix[2]), .row0_col3_o(matrix[3]),
    .row1_col0_o(matrix[4]), .row1_col1_o(matrix[5]),
    .row1_col2_o(matrix[6]), .row1_col3_o(matrix[7]),
    .row2_col0_o(matrix[8]), .row2_col1_o(matrix[9]),
    .row2_col2_o(matrix[10]), .row2_col3_o(matrix[11])
  );

  pfm_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .action_i,
    .normal_x_i, .normal_y_i, .normal_z_i,
    .origin_x_i, .origin_y_i, .origin_z_i, .plane_scale_i,
    .done_i(done_o), .matrix_i(matrix),
    .err_cnt_o(err_cnt), .pending_o(pending), .matrix_cnt_o(matrix_cnt)
  );

  // Picks a random 16-bit value, biased toward corners and tiny magnitudes
  // so that the short normal and saturation cases come up often.
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 10)) - 5);
      3: return 16'($signed($urandom_range(0, 8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // Presents one item; start stays high across back-to-back items and is
  // lowered only when an idle cycle follows. The sender idles at idle_pct.
  task automatic send_item(input logic act, input logic [15:0] nx, ny, nz,
                           input logic [15:0] ox, oy, oz, input logic [14:0] s);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    normal_x_i <= nx; normal_y_i <= ny; normal_z_i <= nz;
    origin_x_i <= ox; origin_y_i <= oy; origin_z_i <= oz;
    plane_scale_i <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    item_cnt++;
  endtask

  task automatic send_random();
    logic [15:0] nx, ny, nz;
    nx = pick16(); ny = pick16(); nz = pick16();
    // Some items point close to the y axis to exercise the +X reference.
    if ($urandom_range(0, 5) == 0) begin
      ny = $urandom_range(0, 1) ? 16'sd4096 : -16'sd4096;
      nx = 16'($signed($urandom_range(0, 1200)) - 600);
      nz = 16'($signed($urandom_range(0, 1200)) - 600);
    end
    send_item(1'($urandom_range(0, 1)), nx, ny, nz, pick16(), pick16(), pick16(),
              $urandom_range(0, 3) == 0 ? 15'h7fff : 15'($urandom));
  endtask

  initial begin
    idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: axis normals, zero and tiny normals, near-Y on both sides
    // of the threshold, extreme origins and scales, both actions.
    for (int a = 0; a < 2; a++) begin
      send_item(1'(a), 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff,
                15'h7fff);
      send_item(1'(a), 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                15'h7fff);
      send_item(1'(a), 16'sd4096, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
                15'h0000);
      send_item(1'(a), 16'h0000, 16'sd4096, 16'h0000, 16'h1000, 16'h2000, 16'h3000,
                15'h1000);
      send_item(1'(a), 16'h0000, -16'sd4096, 16'h0000, 16'h7fff, 16'h7fff, 16'h7fff,
                15'h4000);
      send_item(1'(a), 16'h0000, 16'h0000, 16'sd4096, 16'h7fff, 16'h8000, 16'h0001,
                15'h7fff);
      send_item(1'(a), 16'h0000, 16'h0000, -16'sd4096, 16'h8000, 16'h7fff, 16'hffff,
                15'h1000);
      send_item(1'(a), 16'sd580, 16'sd4055, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                15'h1000);
      send_item(1'(a), 16'sd600, 16'sd4052, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
                15'h1000);
      send_item(1'(a), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000,
                15'h7fff);
      send_item(1'(a), 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h0000,
                15'h5555);
      send_item(1'(a), 16'h8000, 16'h7fff, 16'h0004, 16'hffff, 16'h0001, 16'h7fff,
                15'h0000);
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 81 : (ph == 3) ? 13 : 0;
      repeat (400) send_random();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (pfm_pkg::LATENCY + 10) @(posedge clk_i);
    $display("Sent %0d plane items over four idling phases; %0d matrices checked.",
             item_cnt, matrix_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pfm_pkg.sv
rtl/core/pfm_isqrt.sv
rtl/core/pfm_norm.sv
rtl/core/pfm_emit.sv
rtl/core/plane_frame_matrix_core.sv
rtl/core/pfm_checker.sv
test/pfm_checker.sv
test/tb.sv
